// ----- hw/rtl/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, codes and the CRC-16 byte step of the link frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam logic [15:0] MAX_LEN_RESET = 16'd257;

	// Result kinds.
	localparam logic [1:0] KIND_PCTR    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Verdict codes.
	localparam logic [2:0] STAT_DATA_OK  = 3'd0;
	localparam logic [2:0] STAT_CTRL_OK  = 3'd1;
	localparam logic [2:0] STAT_CRC_ERR  = 3'd2;
	localparam logic [2:0] STAT_HDR_ERR  = 3'd3;
	localparam logic [2:0] STAT_TRUNC    = 3'd4;

	// Reply byte prefixes and the empty reply.
	localparam logic [5:0] ACK_PREFIX = 6'b100000;
	localparam logic [2:0] NAK_PREFIX = 3'b101;
	localparam logic [7:0] REPLY_NONE = 8'h00;

	// Byte positions within a frame with a fixed meaning.
	localparam logic [16:0] POS_LEN_HI = 17'd1;
	localparam logic [16:0] POS_LEN_LO = 17'd2;
	localparam logic [16:0] POS_PCTR   = 17'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [2:0] status;
		logic [7:0] reply_byte;
		logic [1:0] frame_number;
	} result_t;

	// One CRC step in nibble form, seed and result kept to 16 bits.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [7:0]  a;
		logic [3:0]  b;
		logic [7:0]  c;
		logic [3:0]  d;
		logic [15:0] t;
		a = crc[7:0] ^ data;
		b = a[3:0];
		c = {b, 4'h0} ^ a;
		d = c[7:4];
		t = {7'h00, c, 1'b0} ^ {12'h000, d};
		t = {t[11:0], 4'h0} ^ {12'h000, b};
		t = {t[12:0], 3'b000};
		crc_byte = t ^ {12'h000, d} ^ {8'h00, crc[15:8]};
	endfunction

endpackage

// ----- hw/rtl/link_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// link_frame_receiver_unit
// Checks CRC-16 protected link frames and passes on packet bytes and verdicts.
// ----------------------------------------------------------------------------
// Input words are held in the input register and results in the result register.
// Throughput: one input word per cycle unless the output stalls, set by the combinational CRC byte step.
// Reset (arst_n low, asynchronous) empties both registers, closes any open
// frame, sets the expected frame number to 0 and the length limit to 257.
module link_frame_receiver_unit import lfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic [7:0]  reply_byte,
	output logic [1:0]  frame_number
);

	// The word in the input register is processed in the cycle in which the
	// result register can take a new value, whether or not it gives a result.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       load;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_q;

	assign step = valid_s1 && load;

	lfr_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.take        (load),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.start_s1    (start_s1)
	);

	// Frame logic: the state advances only on a processed word, so a stalled
	// output holds both the input register and the frame state.
	lfr_frame_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.byte_s1     (byte_s1),
		.start_s1    (start_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register; a word that gives no result simply leaves it empty.
	lfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (step && res_valid),
		.res       (res),
		.load      (load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	assign kind         = out_q.kind;
	assign data_byte    = out_q.data_byte;
	assign status       = out_q.status;
	assign reply_byte   = out_q.reply_byte;
	assign frame_number = out_q.frame_number;

	// A good data frame is always answered with an ACK for its own number.
	a_ack_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VERDICT && status == STAT_DATA_OK |->
		reply_byte == {ACK_PREFIX, frame_number})
		else $error("data ok verdict without matching ACK");

	// Packet bytes carry no verdict and no reply.
	a_bytes_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_VERDICT |->
		status == STAT_DATA_OK && reply_byte == REPLY_NONE)
		else $error("packet byte carries verdict or reply");

	// The input side stalls only while a word sits unprocessed in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked word");

	// A result taken into the output register always comes from a processed word.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step && res_valid))
		else $error("result appeared without a processed word");

endmodule

// ----- hw/rtl/lfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// lfr_in_stage
// Input register: holds one received word until the frame logic takes it.
// ----------------------------------------------------------------------------
module lfr_in_stage import lfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       start_s1
);

	// The stage is free when empty or when its word moves on this cycle.
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

endmodule

// ----- hw/rtl/lfr_frame_check.sv -----
// ----------------------------------------------------------------------------
// lfr_frame_check
// Frame state, CRC accumulation and header/FCS checks; one word per cycle while step is high.
// ----------------------------------------------------------------------------
module lfr_frame_check import lfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        step,
	input  logic [7:0]  byte_s1,
	input  logic        start_s1,
	output logic        res_valid,
	output result_t     res
);

	logic        in_frame_q, dropping_q;
	logic [16:0] pos_q;
	logic [7:0]  hdr_q;
	logic [15:0] len_q;
	logic [15:0] crc_q;
	logic [7:0]  fcs_hi_q;
	logic [1:0]  efn_q;
	logic [15:0] max_len_q;

	logic        in_frame_d, dropping_d;
	logic [16:0] pos_d;
	logic [7:0]  hdr_d;
	logic [15:0] len_d;
	logic [15:0] crc_d;
	logic [7:0]  fcs_hi_d;
	logic [1:0]  efn_d;

	logic [15:0] crc_next;
	logic [15:0] len_full;
	logic [16:0] fcs_pos;
	logic        control;
	logic        hdr_ok;
	logic        fcs_good;

	assign control  = hdr_q[7];
	assign crc_next = crc_byte(crc_q, byte_s1);
	assign len_full = {len_q[15:8], byte_s1};
	assign fcs_pos  = {1'b0, len_q} + POS_PCTR;
	assign fcs_good = {fcs_hi_q, byte_s1} == crc_q;
	assign hdr_ok   = control ? (len_full == 16'd0)
	                          : (hdr_q == {4'h0, efn_q, 2'b00}) && (len_full != 16'd0) &&
	                            (len_full <= max_len_q);

	always_comb begin
		in_frame_d = in_frame_q;
		dropping_d = dropping_q;
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		len_d      = len_q;
		crc_d      = crc_q;
		fcs_hi_d   = fcs_hi_q;
		efn_d      = efn_q;
		res_valid  = 1'b0;
		res.kind         = KIND_VERDICT;
		res.data_byte    = 8'h00;
		res.status       = STAT_DATA_OK;
		res.reply_byte   = REPLY_NONE;
		res.frame_number = efn_q;
		if (start_s1) begin
			if (in_frame_q && !dropping_q) begin
				res_valid  = 1'b1;
				res.status = STAT_TRUNC;
			end
			in_frame_d = 1'b1;
			dropping_d = 1'b0;
			hdr_d      = byte_s1;
			len_d      = 16'd0;
			fcs_hi_d   = 8'h00;
			crc_d      = crc_byte(16'h0000, byte_s1);
			pos_d      = POS_LEN_HI;
		end else if (in_frame_q && !dropping_q) begin
			if (pos_q == POS_LEN_HI) begin
				len_d = {byte_s1, 8'h00};
				crc_d = crc_next;
				pos_d = POS_LEN_LO;
			end else if (pos_q == POS_LEN_LO) begin
				len_d = len_full;
				crc_d = crc_next;
				pos_d = POS_PCTR;
				if (!hdr_ok) begin
					dropping_d = 1'b1;
					res_valid  = 1'b1;
					res.status = STAT_HDR_ERR;
				end
			end else if (pos_q < fcs_pos) begin
				crc_d         = crc_next;
				pos_d         = pos_q + 17'd1;
				res_valid     = 1'b1;
				res.kind      = (pos_q == POS_PCTR) ? KIND_PCTR : KIND_PAYLOAD;
				res.data_byte = byte_s1;
			end else if (pos_q == fcs_pos) begin
				fcs_hi_d = byte_s1;
				pos_d    = pos_q + 17'd1;
			end else begin
				in_frame_d = 1'b0;
				dropping_d = 1'b0;
				pos_d      = 17'd0;
				res_valid  = 1'b1;
				if (control) begin
					res.data_byte = hdr_q;
					res.status    = fcs_good ? STAT_CTRL_OK : STAT_CRC_ERR;
				end else if (fcs_good) begin
					res.status     = STAT_DATA_OK;
					res.reply_byte = {ACK_PREFIX, efn_q};
					efn_d          = efn_q + 2'd1;
				end else begin
					res.status     = STAT_CRC_ERR;
					res.reply_byte = {NAK_PREFIX, efn_q, 3'b000};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			dropping_q <= 1'b0;
			pos_q      <= 17'd0;
			hdr_q      <= 8'h00;
			len_q      <= 16'd0;
			crc_q      <= 16'h0000;
			fcs_hi_q   <= 8'h00;
			efn_q      <= 2'd0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			dropping_q <= dropping_d;
			pos_q      <= pos_d;
			hdr_q      <= hdr_d;
			len_q      <= len_d;
			crc_q      <= crc_d;
			fcs_hi_q   <= fcs_hi_d;
			efn_q      <= efn_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule

// ----- hw/rtl/lfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// lfr_out_stage
// Result register toward the consumer; frees itself whenever its word is taken.
// ----------------------------------------------------------------------------
module lfr_out_stage import lfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    load,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_q
);

	assign load = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			out_q <= res;
		end
	end

endmodule

// ----- tb/lfr_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfr_frame_checker
// Watches the word channels and the limit register of the link frame receiver,
// keeps its own copy of the frame state and checks every result word in order.
// ----------------------------------------------------------------------------
module lfr_frame_checker import lfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  status,
	input  logic [7:0]  reply_byte,
	input  logic [1:0]  frame_number,
	output int          fail_count,
	output int          pending
);

	// Reflected form of the x^16 + x^12 + x^5 + 1 polynomial, shifted out LSB first.
	localparam logic [15:0] CRC_POLY_LSB = 16'h8408;
	localparam int          SHOW_LIMIT   = 10;

	logic        in_frm;
	logic        drop;
	logic [16:0] pos;
	logic [7:0]  hdr_ctl;
	logic [15:0] flen;
	logic [15:0] crc_acc;
	logic [7:0]  fcs_hi_q;
	logic [1:0]  seq_exp;
	logic [15:0] len_limit;
	result_t     awaited_results[$];
	int          results_seen;

	function automatic logic [15:0] crc16_lsb_first(input logic [15:0] acc, input logic [7:0] v);
		logic [15:0] r;
		r = acc ^ {8'h00, v};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY_LSB) : (r >> 1);
		return r;
	endfunction

	// Advances the frame state by one accepted input word and queues what it yields.
	task track_rx_word(input logic [7:0] b, input logic st);
		result_t     w;
		logic        is_ctrl;
		logic        hdr_ok;
		logic [15:0] fcs;
		is_ctrl = hdr_ctl[7];
		w = '0;
		w.frame_number = seq_exp;
		if (st) begin
			if (in_frm && !drop) begin
				w.kind = KIND_VERDICT;
				w.status = STAT_TRUNC;
				w.reply_byte = REPLY_NONE;
				awaited_results.push_back(w);
			end
			in_frm = 1'b1;
			drop = 1'b0;
			hdr_ctl = b;
			flen = 16'h0000;
			fcs_hi_q = 8'h00;
			crc_acc = crc16_lsb_first(16'h0000, b);
			pos = POS_LEN_HI;
		end else if (in_frm && !drop) begin
			if (pos == POS_LEN_HI) begin
				flen = {b, 8'h00};
				crc_acc = crc16_lsb_first(crc_acc, b);
				pos = POS_LEN_LO;
			end else if (pos == POS_LEN_LO) begin
				flen[7:0] = b;
				crc_acc = crc16_lsb_first(crc_acc, b);
				pos = POS_PCTR;
				if (is_ctrl)
					hdr_ok = (flen == 16'h0000);
				else
					hdr_ok = (hdr_ctl == {4'b0000, seq_exp, 2'b00}) && (flen != 16'h0000)
						&& (flen <= len_limit);
				if (!hdr_ok) begin
					drop = 1'b1;
					w.kind = KIND_VERDICT;
					w.status = STAT_HDR_ERR;
					w.reply_byte = REPLY_NONE;
					awaited_results.push_back(w);
				end
			end else if (pos < POS_PCTR + flen) begin
				w.kind = (pos == POS_PCTR) ? KIND_PCTR : KIND_PAYLOAD;
				w.data_byte = b;
				crc_acc = crc16_lsb_first(crc_acc, b);
				pos = pos + 17'd1;
				awaited_results.push_back(w);
			end else if (pos == POS_PCTR + flen) begin
				fcs_hi_q = b;
				pos = pos + 17'd1;
			end else begin
				fcs = {fcs_hi_q, b};
				in_frm = 1'b0;
				drop = 1'b0;
				pos = '0;
				w.kind = KIND_VERDICT;
				if (is_ctrl) begin
					w.data_byte = hdr_ctl;
					w.status = (fcs == crc_acc) ? STAT_CTRL_OK : STAT_CRC_ERR;
					w.reply_byte = REPLY_NONE;
				end else if (fcs == crc_acc) begin
					w.status = STAT_DATA_OK;
					w.reply_byte = {ACK_PREFIX, seq_exp};
					seq_exp = seq_exp + 2'd1;
				end else begin
					w.status = STAT_CRC_ERR;
					w.reply_byte = {NAK_PREFIX, seq_exp, 3'b000};
				end
				awaited_results.push_back(w);
			end
		end
	endtask

	task check_result_word();
		result_t got;
		result_t want;
		got = {kind, data_byte, status, reply_byte, frame_number};
		if (awaited_results.size() == 0) begin
			if (fail_count < SHOW_LIMIT)
				$display("lfr_checker: result word %0d with nothing expected: kind=%0d data=%02h status=%0d reply=%02h fnum=%0d",
					results_seen, got.kind, got.data_byte, got.status, got.reply_byte,
					got.frame_number);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			if (got !== want) begin
				if (fail_count < SHOW_LIMIT)
					$display("lfr_checker: result word %0d: expected kind=%0d data=%02h status=%0d reply=%02h fnum=%0d, got kind=%0d data=%02h status=%0d reply=%02h fnum=%0d",
						results_seen, want.kind, want.data_byte, want.status,
						want.reply_byte, want.frame_number, got.kind, got.data_byte,
						got.status, got.reply_byte, got.frame_number);
				fail_count++;
			end
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frm = 1'b0;
			drop = 1'b0;
			pos = '0;
			hdr_ctl = 8'h00;
			flen = 16'h0000;
			crc_acc = 16'h0000;
			fcs_hi_q = 8'h00;
			seq_exp = 2'd0;
			len_limit = MAX_LEN_RESET;
			awaited_results.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_wr_en)
				len_limit = cfg_wr_data;
			if (in_valid && !in_stall)
				track_rx_word(rx_byte, frame_start);
			if (out_valid && !out_stall)
				check_result_word();
		end
		pending = awaited_results.size();
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives framed link bytes and length limit settings into the link frame
// receiver, with random gaps and stalls on both channels; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
	import lfr_pkg::*;

	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         LONG_HOLD   = 200;
	localparam int         DRAIN_PAD   = 4;
	localparam int         MAX_GAP     = 14;
	localparam int         PHASE_WORDS = 300;
	// FCTR bit 7 marks a control frame.
	localparam logic [7:0] CTRL_FLAG   = 8'h80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [7:0]  reply_byte;
	logic [1:0]  frame_number;

	int          fail_total;
	int          pending_words;
	int          cycle_count = 0;

	// Sender side view of the link: the frame number the block waits for, the
	// limit in force and whether a frame was left open on purpose.
	logic        sender_calm;
	logic        recv_calm;
	logic        hold_request;
	logic        line_open;
	logic [1:0]  tx_seq;
	logic [15:0] max_len;
	int          frame_words;

	link_frame_receiver_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.status       (status),
		.reply_byte   (reply_byte),
		.frame_number (frame_number)
	);

	lfr_frame_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.status       (status),
		.reply_byte   (reply_byte),
		.frame_number (frame_number),
		.fail_count   (fail_total),
		.pending      (pending_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a word is lost or a channel hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// FCS generation on the sending side, written in the byte-at-once form:
	// fold the byte in, mix the low nibble up, then combine three shifts.
	function automatic logic [15:0] fcs_nibble_step(input logic [15:0] acc, input logic [7:0] v);
		logic [7:0] t;
		t = v ^ acc[7:0];
		t = t ^ {t[3:0], 4'h0};
		return {t, acc[15:8]} ^ {12'h000, t[7:4]} ^ {5'b00000, t, 3'b000};
	endfunction

	// FCTR that the block accepts for the next data frame.
	function automatic logic [7:0] data_fctr();
		return {4'b0000, tx_seq, 2'b00};
	endfunction

	// Packet lengths are mostly short; now and then exactly 1 or, with a limit up to 300, the limit.
	function automatic logic [15:0] pick_len();
		logic [31:0] rnd;
		int          r;
		r = $urandom_range(0, 15);
		if (r == 0)
			rnd = 1;
		else if (r == 1 && max_len <= 16'd300)
			rnd = max_len;
		else
			rnd = $urandom_range(1, (max_len < 16'd20) ? max_len : 20);
		return rnd[15:0];
	endfunction

	// Offers one word on the input channel after a random gap and returns at
	// the falling edge after it was taken. Valid stays high between words sent
	// back to back, so it is never dropped and raised in the same step.
	task automatic send_word(input logic [7:0] b, input logic st);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= st;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sends FCTR, the length field, body packet bytes and the FCS (xored with
	// fcs_flip to corrupt it). The length field and the body need not agree:
	// frames with a rejected header carry a short body that the block drops.
	// A nonzero cut stops after that many words and leaves the frame open.
	task automatic emit_frame(input logic [7:0] fctr, input logic [15:0] len_field,
			input int body, input int fill, input logic [15:0] fcs_flip, input int cut);
		logic [15:0] acc;
		logic [15:0] fcs;
		logic [7:0]  v;
		logic [31:0] rnd;
		int          total;
		acc = 16'h0000;
		fcs = 16'h0000;
		total = body + 5;
		for (int i = 0; i < total; i++) begin
			if (cut != 0 && i >= cut)
				break;
			rnd = $urandom;
			if (i == 0)
				v = fctr;
			else if (i == 1)
				v = len_field[15:8];
			else if (i == 2)
				v = len_field[7:0];
			else if (i < body + 3)
				v = (fill < 0) ? rnd[7:0] : fill[7:0];
			else if (i == body + 3)
				v = fcs[15:8];
			else
				v = fcs[7:0];
			if (i < body + 3) begin
				acc = fcs_nibble_step(acc, v);
				if (i == body + 2)
					fcs = acc ^ fcs_flip;
			end
			send_word(v, i == 0);
			frame_words++;
		end
		line_open = (cut != 0);
	endtask

	// A frame left open on purpose is cut off by a good control frame: a truncated
	// verdict, if the frame was not already rejected, then a control verdict.
	task automatic close_line();
		if (line_open)
			emit_frame(CTRL_FLAG, 16'h0000, 0, -1, 16'h0000, 0);
	endtask

	// Waits until every predicted word has come out, then pads by DRAIN_PAD
	// because the last words taken may have been ones that yield nothing.
	task automatic drain();
		while (pending_words != 0)
			@(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	// The limit is only changed with the block idle and no frame open.
	task automatic set_limit(input logic [15:0] v);
		close_line();
		in_valid <= 1'b0;
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_len = v;
	endtask

	// One random frame or a burst of stray bytes. About half are good data
	// frames so that the frame number keeps moving; the rest are control
	// frames, CRC errors, rejected headers and frames cut short.
	task automatic random_frame();
		logic [31:0] rnd;
		logic [15:0] len;
		logic [7:0]  f;
		int          sel;
		sender_calm = ($urandom_range(0, 4) == 0);
		recv_calm = ($urandom_range(0, 4) == 0);
		sel = $urandom_range(0, 99);
		// Stray bytes would be taken as frame bytes while a frame is open.
		if (sel < 4 && line_open)
			sel = 50;
		len = pick_len();
		rnd = $urandom;
		f = CTRL_FLAG | rnd[7:0];
		if (sel < 4) begin
			for (int i = $urandom_range(1, 3); i > 0; i--) begin
				rnd = $urandom;
				send_word(rnd[7:0], 1'b0);
			end
		end else if (sel < 54) begin
			emit_frame(data_fctr(), len, len, -1, 16'h0000, 0);
			tx_seq = tx_seq + 2'd1;
		end else if (sel < 64) begin
			emit_frame(f, 16'h0000, 0, -1, 16'h0000, 0);
		end else if (sel < 72) begin
			rnd = $urandom_range(1, 65535);
			emit_frame(data_fctr(), len, len, -1, rnd[15:0], 0);
		end else if (sel < 76) begin
			rnd = $urandom_range(1, 65535);
			emit_frame(f, 16'h0000, 0, -1, rnd[15:0], 0);
		end else if (sel < 82) begin
			// Data FCTR with a wrong frame number or other stray bits.
			rnd = $urandom_range(0, 127);
			f = rnd[7:0];
			if (f == data_fctr())
				f = f ^ (8'h01 << $urandom_range(0, 6));
			emit_frame(f, len, $urandom_range(0, 3), -1, 16'h0000, 0);
		end else if (sel < 88) begin
			// Length of zero, just past the limit, or far past it.
			if ($urandom_range(0, 1) == 0 || max_len == 16'hFFFF)
				len = 16'h0000;
			else if ($urandom_range(0, 1) == 0)
				len = max_len + 16'd1;
			else begin
				rnd = $urandom_range(max_len + 1, 65535);
				len = rnd[15:0];
			end
			emit_frame(data_fctr(), len, $urandom_range(0, 3), -1, 16'h0000, 0);
		end else if (sel < 92) begin
			rnd = $urandom_range(1, 65535);
			emit_frame(f, rnd[15:0], $urandom_range(0, 3), -1, 16'h0000, 0);
		end else begin
			// Cut anywhere from just after FCTR to just before the last FCS byte.
			rnd = $urandom_range(1, len + 4);
			emit_frame(data_fctr(), len, len, -1, 16'h0000, rnd);
		end
	endtask

	task automatic run_random(input int words);
		int first;
		first = frame_words;
		while (frame_words - first < words)
			random_frame();
	endtask

	// Output side: before each result word the receiver stalls for a random
	// number of cycles, or for one long stretch when the sender asks for it.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = 0;
			if (hold_request) begin
				hold_request = 1'b0;
				n = LONG_HOLD;
			end else if (!recv_calm)
				n = $urandom_range(0, MAX_GAP);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		logic [31:0] rnd;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		frame_start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'h0000;
		arst_n = 1'b0;
		sender_calm = 1'b0;
		recv_calm = 1'b0;
		hold_request = 1'b0;
		line_open = 1'b0;
		tx_seq = 2'd0;
		max_len = MAX_LEN_RESET;
		frame_words = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening at the reset limit.
		// A byte outside any frame is ignored.
		send_word(8'hFF, 1'b0);
		// Good control frame with every FCTR bit set.
		emit_frame(8'hFF, 16'h0000, 0, -1, 16'h0000, 0);
		// Shortest data frame, PCTR all zeros: ACK and the frame number moves on.
		emit_frame(data_fctr(), 16'd1, 1, 8'h00, 16'h0000, 0);
		tx_seq = tx_seq + 2'd1;
		// PCTR all ones and every FCS bit flipped: NAK, no advance.
		emit_frame(data_fctr(), 16'd1, 1, 8'hFF, 16'hFFFF, 0);
		// Control frame with a length is rejected and left dropping; the next
		// start must not report it as cut off.
		emit_frame(CTRL_FLAG, 16'h0100, 0, -1, 16'h0000, 3);
		// Data frame cut right after its PCTR ...
		emit_frame(data_fctr(), 16'd3, 3, -1, 16'h0000, 4);
		// ... by a frame with the wrong frame number.
		emit_frame(data_fctr() ^ 8'h04, 16'd2, 0, -1, 16'h0000, 3);

		// Smallest limit: every good data frame is a lone PCTR.
		set_limit(16'd1);
		run_random(PHASE_WORDS);

		// Largest limit.
		set_limit(16'hFFFF);
		run_random(PHASE_WORDS);

		// Some small limit. The receiver holds off for a long stretch while
		// the sender keeps offering a whole frame, so the block fills and
		// stalls its input; then the sender waits until everything is out.
		rnd = $urandom_range(2, 64);
		set_limit(rnd[15:0]);
		sender_calm = 1'b1;
		recv_calm = 1'b0;
		hold_request = 1'b1;
		emit_frame(data_fctr(), max_len, max_len, -1, 16'h0000, 0);
		tx_seq = tx_seq + 2'd1;
		in_valid <= 1'b0;
		drain();
		run_random(PHASE_WORDS);

		// Back to the reset value.
		set_limit(MAX_LEN_RESET);
		run_random(PHASE_WORDS);

		close_line();
		in_valid <= 1'b0;
		drain();
		if (fail_total == 0 && pending_words == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/lfr_pkg.sv
hw/rtl/lfr_in_stage.sv
hw/rtl/lfr_frame_check.sv
hw/rtl/lfr_out_stage.sv
hw/rtl/link_frame_receiver_unit.sv
tb/lfr_frame_checker.sv
tb/tb_top.sv
